### rtl/core/fcelm_pkg.sv
// ----------------------------------------------------------------------------
// fcelm_pkg
// Shared types and constants for the Frei-Chen edge/line measure block.
// ----------------------------------------------------------------------------
package fcelm_pkg;

    localparam int unsigned SQ2_FIX    = 23170;
    localparam int unsigned MAX_HEIGHT = 1024;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [1:0] MODE_BOTH  = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    // energies are below 2^103; keep 104 bits
    localparam int unsigned EW = 104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROJ,
        ST_ENERGY,
        ST_SUM,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_pixel;   // latch pixel, issue line-store read
        logic pick_window;  // assemble the 3x3 for the current result
        logic proj;         // compute projections
        logic energy;       // square the projections
        logic sum;          // weighted sums into numerator and denominator
        logic div_init;
        logic div_step;
        logic out_load;     // move result into output register
        logic commit;       // update stores, window and counters
        logic restart;      // counters back to origin
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] n_results;
        logic       iter_done;
        logic       den_zero;
    } status_t;

endpackage

### rtl/core/frei_chen_edge_line_measure.sv
// Each accepted pixel is read; if it closes no result it is committed at
// once, else for each result the window is picked, projected, squared and
// summed, then a 33-bit quotient and a 17-bit root are formed on one shared
// unit (both skipped when the window energy is zero). Output stalls hold the
// result step; a new pixel is taken only after its last result is loaded.
// Reset: async active low; counters and window clear, line stores do not.
// ----------------------------------------------------------------------------
// frei_chen_edge_line_measure
// Frei-Chen 3x3 edge/line energy ratio, square root, on a raster stream.
// ----------------------------------------------------------------------------
module frei_chen_edge_line_measure
    import fcelm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned PIXEL_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] measure,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        run_last,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    logic [1:0]  mode_reg;
    logic [10:0] width_reg, height_reg;
    logic        cfg_wr, restart;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BOTH;
            width_reg  <= 11'd320;
            height_reg <= 11'd240;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    cmd_t       cmd;
    status_t    status;
    logic [1:0] res_idx;

    fcelm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .cfg_restart (restart),
        .status      (status),
        .cmd         (cmd),
        .res_idx     (res_idx)
    );

    fcelm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res_idx    (res_idx),
        .pixel      (pixel),
        .mode       (mode_reg),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .status     (status),
        .measure    (measure),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

### rtl/core/fcelm_ctrl.sv
// ----------------------------------------------------------------------------
// fcelm_ctrl
// Sequencer: one pixel at a time, up to four results, each through a
// shared bit-serial divider and square root.
// ----------------------------------------------------------------------------
module fcelm_ctrl
    import fcelm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    input  logic    cfg_restart,
    input  status_t status,
    output cmd_t    cmd,
    output logic [1:0] res_idx
);

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign res_idx   = idx_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.restart = cfg_restart;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_READ;
                    idx_next       = '0;
                end
            end
            ST_READ:
            begin
                if (status.n_results == 3'd0)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.pick_window = 1'b1;
                    state_next      = ST_PROJ;
                end
            end
            ST_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = ST_ENERGY;
            end
            ST_ENERGY:
            begin
                cmd.energy   = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum      = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (status.iter_done)
                begin
                    state_next = ST_OUT;
                end
                else if (status.den_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_step  = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    if ({1'b0, idx_reg} + 3'd1 == status.n_results)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // window is picked once the new index is registered
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/fcelm_datapath.sv
// ----------------------------------------------------------------------------
// fcelm_datapath
// Line stores, window, projections, energies, divider and square root.
// ----------------------------------------------------------------------------
module fcelm_datapath
    import fcelm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned PIXEL_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [1:0]  res_idx,
    input  logic [7:0]  pixel,
    input  logic [1:0]  mode,
    input  logic [10:0] width_cfg,
    input  logic [10:0] height_cfg,
    output status_t     status,
    output logic [15:0] measure,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        run_last,
    output logic        frame_end
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned PB = PIXEL_BITS;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned VW = PB + 6;   // signed projection width
    localparam int unsigned PW = PB + 21;  // edge projection width
    localparam int unsigned SQ2_W = 15;

    // effective geometry
    logic [CW-1:0] w_eff;
    logic [10:0]   h_eff;
    always_comb
    begin
        if (width_cfg == 11'd0)
            w_eff = CW'(1);
        else if (32'(width_cfg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_cfg);
        if (height_cfg == 11'd0)
            h_eff = 11'd1;
        else if (32'(height_cfg) > MAX_HEIGHT)
            h_eff = 11'(MAX_HEIGHT);
        else
            h_eff = height_cfg;
    end

    logic [CW-1:0] col_reg;
    logic [10:0]   row_reg;
    logic [CW-1:0] c_eff;
    logic [10:0]   r_eff;
    assign c_eff = (col_reg >= w_eff) ? '0 : col_reg;
    assign r_eff = (row_reg >= h_eff) ? '0 : row_reg;

    logic [PB-1:0] older_mem [MAX_WIDTH];
    logic [PB-1:0] newer_mem [MAX_WIDTH];
    logic [PB-1:0] older_q, newer_q, pix_reg;
    logic [PB-1:0] win_reg [6];

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            older_q <= older_mem[c_eff[AW-1:0]];
            newer_q <= newer_mem[c_eff[AW-1:0]];
            pix_reg <= PB'(pixel);
        end
        if (cmd.commit)
        begin
            older_mem[c_eff[AW-1:0]] <= newer_q;
            newer_mem[c_eff[AW-1:0]] <= pix_reg;
        end
    end

    logic last_col, last_row;
    assign last_col = (c_eff == w_eff - CW'(1));
    assign last_row = (r_eff == h_eff - 11'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int k = 0; k < 6; k++)
                win_reg[k] <= '0;
        end
        else if (cmd.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.commit)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= older_q;
            win_reg[1] <= newer_q;
            win_reg[2] <= pix_reg;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? 11'd0 : r_eff + 11'd1;
            end
            else
            begin
                col_reg <= c_eff + CW'(1);
                row_reg <= r_eff;
            end
        end
    end

    // result list: pass (row) then sub (column)
    logic has_p0, has_p1, has_s0, has_s1;
    assign has_p0 = (r_eff != 11'd0);
    assign has_p1 = last_row;
    assign has_s0 = (c_eff != '0);
    assign has_s1 = last_col;

    logic [1:0] n_p, n_s;
    assign n_p = 2'(has_p0) + 2'(has_p1);
    assign n_s = 2'(has_s0) + 2'(has_s1);
    assign status.n_results = (n_p == 2'd2 ? {n_s, 1'b0} : (n_p == 2'd1 ? {1'b0, n_s} : 3'd0));

    // decode res_idx into pass and sub
    logic pass_sel, sub_sel, idx_col_bit, idx_row_bit;
    assign idx_col_bit = (n_s == 2'd2) ? res_idx[0] : 1'b0;
    assign idx_row_bit = (n_s == 2'd2) ? res_idx[1] : res_idx[0];
    assign pass_sel = has_p0 ? idx_row_bit : 1'b1;
    assign sub_sel  = has_s0 ? idx_col_bit : 1'b1;

    // g[col][row]
    logic [PB-1:0] g [3][3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            g[0][k] = win_reg[3 + k];
            g[1][k] = win_reg[k];
        end
        g[2][0] = older_q;
        g[2][1] = newer_q;
        g[2][2] = pix_reg;
    end

    logic [1:0] lf, ce, rt, tp, md, bt;
    always_comb
    begin
        if (!pass_sel)
        begin
            tp = (r_eff >= 11'd2) ? 2'd0 : 2'd1;
            md = 2'd1;
        end
        else
        begin
            tp = (r_eff >= 11'd1) ? 2'd1 : 2'd2;
            md = 2'd2;
        end
        bt = 2'd2;
        if (!sub_sel)
        begin
            lf = (c_eff >= CW'(2)) ? 2'd0 : 2'd1;
            ce = 2'd1;
        end
        else
        begin
            lf = (c_eff >= CW'(1)) ? 2'd1 : 2'd2;
            ce = 2'd2;
        end
        rt = 2'd2;
    end

    logic [PB-1:0] p_reg [9];
    logic [9:0] orow_reg, ocol_reg;
    logic       last_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.pick_window)
        begin
            p_reg[0] <= g[lf][tp]; p_reg[1] <= g[lf][md]; p_reg[2] <= g[lf][bt];
            p_reg[3] <= g[ce][tp]; p_reg[4] <= g[ce][md]; p_reg[5] <= g[ce][bt];
            p_reg[6] <= g[rt][tp]; p_reg[7] <= g[rt][md]; p_reg[8] <= g[rt][bt];
            orow_reg <= pass_sel ? r_eff[9:0] : 10'(r_eff - 11'd1);
            ocol_reg <= sub_sel ? c_eff[9:0] : 10'(c_eff - CW'(1));
            last_reg <= ({1'b0, res_idx} + 3'd1 == status.n_results);
        end
    end

    // projections
    logic signed [VW-1:0] s [9];
    always_comb
        for (int k = 0; k < 9; k++)
            s[k] = VW'(signed'({1'b0, p_reg[k]}));

    logic signed [PW-1:0] e_reg [4];
    logic signed [VW-1:0] l_reg [4];
    logic signed [VW-1:0] sm_reg;
    logic signed [SQ2_W+1:0] k_sq2;
    assign k_sq2 = (SQ2_W+2)'(SQ2_FIX);

    always_ff @(posedge clk)
    begin
        if (cmd.proj)
        begin
            e_reg[0] <= (PW'(s[0] + s[2] - s[6] - s[8]) <<< 14)
                        + PW'(k_sq2) * PW'(s[1] - s[7]);
            e_reg[1] <= (PW'(s[0] - s[2] + s[6] - s[8]) <<< 14)
                        + PW'(k_sq2) * PW'(s[3] - s[5]);
            e_reg[2] <= (PW'(-s[1] + s[3] - s[5] + s[7]) <<< 14)
                        + PW'(k_sq2) * PW'(s[2] - s[6]);
            e_reg[3] <= (PW'(-s[1] - s[3] + s[5] + s[7]) <<< 14)
                        + PW'(k_sq2) * PW'(s[0] - s[8]);
            l_reg[0] <= s[1] - s[3] - s[5] + s[7];
            l_reg[1] <= -s[0] + s[2] + s[6] - s[8];
            l_reg[2] <= s[0] - (s[1] <<< 1) + s[2] - (s[3] <<< 1) + (s[4] <<< 2)
                        - (s[5] <<< 1) + s[6] - (s[7] <<< 1) + s[8];
            l_reg[3] <= -(s[0] <<< 1) + s[1] - (s[2] <<< 1) + s[3] + (s[4] <<< 2)
                        + s[5] - (s[6] <<< 1) + s[7] - (s[8] <<< 1);
            sm_reg   <= s[0] + s[1] + s[2] + s[3] + s[4] + s[5] + s[6] + s[7] + s[8];
        end
    end

    // energies: squares, then weighted sums
    logic [PW-1:0] ea [4];
    logic [VW-1:0] la [4];
    logic [VW-1:0] sa;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ea[k] = e_reg[k][PW-1] ? PW'(-e_reg[k]) : PW'(e_reg[k]);
            la[k] = l_reg[k][VW-1] ? VW'(-l_reg[k]) : VW'(l_reg[k]);
        end
        sa = sm_reg[VW-1] ? VW'(-sm_reg) : VW'(sm_reg);
    end

    logic [2*PW-1:0] esq_reg [4];
    logic [2*VW-1:0] lsq_reg [4];
    logic [2*VW-1:0] ssq_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.energy)
        begin
            for (int k = 0; k < 4; k++)
            begin
                esq_reg[k] <= (2*PW)'(ea[k]) * (2*PW)'(ea[k]);
                lsq_reg[k] <= (2*VW)'(la[k]) * (2*VW)'(la[k]);
            end
            ssq_reg <= (2*VW)'(sa) * (2*VW)'(sa);
        end
    end

    logic [EW-1:0] edge_e, line_e, avg_e, num_e, den_e;
    always_comb
    begin
        edge_e = (EW'(esq_reg[0]) + EW'(esq_reg[1]) + EW'(esq_reg[2])
                + EW'(esq_reg[3])) * EW'(81);
        line_e = ((EW'(lsq_reg[0]) + EW'(lsq_reg[1])) * EW'(162)
                + (EW'(lsq_reg[2]) + EW'(lsq_reg[3])) * EW'(18)) << 28;
        avg_e  = (EW'(ssq_reg) * EW'(8)) << 28;
    end

    logic [EW-1:0] num_reg, den_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            unique case (mode)
                MODE_EDGE: num_reg <= edge_e;
                MODE_LINE: num_reg <= line_e;
                default:   num_reg <= edge_e + line_e;
            endcase
            den_reg <= edge_e + line_e + avg_e;
        end
    end
    assign num_e = num_reg;
    assign den_e = den_reg;

    // restoring divider (33 quotient bits), then digit-by-digit root
    logic [EW:0]   rem_reg;
    logic [31:0]   q_reg;
    logic [5:0]    dcnt_reg;
    logic [33:0]   rx_reg;
    logic [33:0]   rres_reg;
    logic [33:0]   rbit_reg;
    logic          dphase_reg;
    logic [EW:0]   rem_sh, rem_try;
    logic [33:0]   rsum;

    assign rem_sh  = (dcnt_reg == 6'd0) ? rem_reg : {rem_reg[EW-1:0], 1'b0};
    assign rem_try = rem_sh - {1'b0, den_e};
    assign rsum    = rres_reg + rbit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg   <= '0;
            dphase_reg <= 1'b0;
        end
        else if (cmd.div_init)
        begin
            dcnt_reg   <= '0;
            dphase_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (!dphase_reg)
            begin
                if (dcnt_reg == 6'd32)
                    dphase_reg <= 1'b1;
                else
                    dcnt_reg <= dcnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= {1'b0, num_e};
            q_reg    <= '0;
            rres_reg <= '0;
            rbit_reg <= 34'h1 << 32;
        end
        else if (cmd.div_step)
        begin
            if (!dphase_reg)
            begin
                if (!rem_try[EW])
                begin
                    rem_reg <= rem_try;
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
                if (dcnt_reg == 6'd32)
                    rx_reg <= {1'b0, q_reg, !rem_try[EW]};
            end
            else
            begin
                if (rx_reg >= rsum)
                begin
                    rx_reg   <= rx_reg - rsum;
                    rres_reg <= (rres_reg >> 1) + rbit_reg;
                end
                else
                    rres_reg <= rres_reg >> 1;
                rbit_reg <= rbit_reg >> 2;
            end
        end
    end

    assign status.iter_done = dphase_reg && (rbit_reg == '0);
    assign status.den_zero  = (den_e == '0);

    logic [15:0] meas_reg;
    logic [9:0]  orow_o_reg, ocol_o_reg;
    logic        last_o_reg, fend_o_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (den_e == '0)
                meas_reg <= '0;
            else if (rres_reg > 34'd65535)
                meas_reg <= 16'hFFFF;
            else
                meas_reg <= rres_reg[15:0];
            orow_o_reg <= orow_reg;
            ocol_o_reg <= ocol_reg;
            last_o_reg <= last_reg;
            fend_o_reg <= (11'(orow_reg) == h_eff - 11'd1)
                          && (CW'(ocol_reg) == w_eff - CW'(1));
        end
    end

    assign measure   = meas_reg;
    assign out_row   = orow_o_reg;
    assign out_col   = ocol_o_reg;
    assign run_last  = last_o_reg;
    assign frame_end = fend_o_reg;

endmodule

### sim/tb_frei_chen_edge_line_measure.sv
// ----------------------------------------------------------------------------
// tb_frei_chen_edge_line_measure
// Streams pixel frames of many shapes through the Frei-Chen measure block.
// A local predictor computes every window result and checks it in order.
// Both handshakes idle at random. Register writes happen between phases.
// ----------------------------------------------------------------------------
module tb_frei_chen_edge_line_measure;
    import fcelm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_MAX  = 1024;
    localparam int SETTLE     = 250;
    localparam int LONG_HOLD  = 700;
    localparam int CYCLE_CAP  = 2000000;
    localparam int ITEM_GOAL  = 345;

    typedef struct packed {
        logic [15:0] measure;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        last;
        logic        fend;
    } window_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  pixel = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] measure;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic        run_last;
    logic        frame_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    frei_chen_edge_line_measure dut (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [1:0]  pm_mode = MODE_BOTH;
    logic [10:0] pm_width = 11'd320;
    logic [10:0] pm_height = 11'd240;
    int          pm_row = 0;
    int          pm_col = 0;
    logic [7:0]  store_older [FRAME_MAX];
    logic [7:0]  store_newer [FRAME_MAX];
    logic [7:0]  win_cols [6];
    int          grid [3][3];

    window_result_t pending_results [$];
    logic [7:0]     pixel_queue [$];
    int  n_sent = 0;
    int  n_accepted = 0;
    int  n_seen = 0;
    int  n_errors = 0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;
    bit  fast_send = 1'b0;
    bit  fast_take = 1'b0;
    int  send_gap = 0;
    int  take_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    initial begin
        foreach (store_older[i]) begin
            store_older[i] = '0;
            store_newer[i] = '0;
        end
        foreach (win_cols[i]) win_cols[i] = '0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] energy_ratio(int lf, int ce, int rt,
                                                 int tp, int md, int bt);
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9, sq2;
        longint e1, e2, e3, e4, l5, l6, l7, l8, sm;
        logic [127:0] edge_e, line_e, avg_e, den, num;
        logic [159:0] quot;
        longint unsigned root;
        sq2 = SQ2_FIX;
        p1 = grid[lf][tp]; p2 = grid[lf][md]; p3 = grid[lf][bt];
        p4 = grid[ce][tp]; p5 = grid[ce][md]; p6 = grid[ce][bt];
        p7 = grid[rt][tp]; p8 = grid[rt][md]; p9 = grid[rt][bt];
        e1 = (p1 + p3 - p7 - p9) * 16384 + sq2 * (p2 - p8);
        e2 = (p1 - p3 + p7 - p9) * 16384 + sq2 * (p4 - p6);
        e3 = (-p2 + p4 - p6 + p8) * 16384 + sq2 * (p3 - p7);
        e4 = (-p2 - p4 + p6 + p8) * 16384 + sq2 * (p1 - p9);
        l5 = p2 - p4 - p6 + p8;
        l6 = -p1 + p3 + p7 - p9;
        l7 = p1 - 2*p2 + p3 - 2*p4 + 4*p5 - 2*p6 + p7 - 2*p8 + p9;
        l8 = -2*p1 + p2 - 2*p3 + p4 + 4*p5 + p6 - 2*p7 + p8 - 2*p9;
        sm = p1 + p2 + p3 + p4 + p5 + p6 + p7 + p8 + p9;
        edge_e = 128'(81 * (e1*e1 + e2*e2 + e3*e3 + e4*e4));
        line_e = 128'(162 * (l5*l5 + l6*l6) + 18 * (l7*l7 + l8*l8)) << 28;
        avg_e  = 128'(8 * sm * sm) << 28;
        den = edge_e + line_e + avg_e;
        if (den == 0) return 16'd0;
        if (pm_mode == MODE_EDGE) num = edge_e;
        else if (pm_mode == MODE_LINE) num = line_e;
        else num = edge_e + line_e;
        quot = {num, 32'd0} / {32'd0, den};
        root = int_sqrt(quot[63:0]);
        return (root > 65535) ? 16'hFFFF : root[15:0];
    endfunction

    // one accepted pixel: push the results it closes, advance the counters
    task automatic window_step(logic [7:0] pix);
        int w, h, r, c, n_out;
        int tp, md, bt, lf, ce, rt;
        window_result_t res [$];
        window_result_t one;
        w = (pm_width == 0) ? 1 : (pm_width > FRAME_MAX ? FRAME_MAX : pm_width);
        h = (pm_height == 0) ? 1 : (pm_height > FRAME_MAX ? FRAME_MAX : pm_height);
        c = (pm_col >= w) ? 0 : pm_col;
        r = (pm_row >= h) ? 0 : pm_row;
        for (int k = 0; k < 3; k++) begin
            grid[0][k] = win_cols[3 + k];
            grid[1][k] = win_cols[k];
        end
        grid[2][0] = store_older[c];
        grid[2][1] = store_newer[c];
        grid[2][2] = pix;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0 && r < 1) continue;
            if (pass == 1 && r != h - 1) continue;
            one.row = (pass == 0) ? 10'(r - 1) : 10'(r);
            tp = (pass == 0) ? (r >= 2 ? 0 : 1) : (r >= 1 ? 1 : 2);
            md = (pass == 0) ? 1 : 2;
            bt = 2;
            for (int sub = 0; sub < 2; sub++) begin
                if (sub == 0 && c < 1) continue;
                if (sub == 1 && c != w - 1) continue;
                one.col = (sub == 0) ? 10'(c - 1) : 10'(c);
                lf = (sub == 0) ? (c >= 2 ? 0 : 1) : (c >= 1 ? 1 : 2);
                ce = (sub == 0) ? 1 : 2;
                rt = 2;
                one.measure = energy_ratio(lf, ce, rt, tp, md, bt);
                one.last = 1'b0;
                one.fend = (int'(one.row) == h - 1 && int'(one.col) == w - 1);
                res.push_back(one);
            end
        end
        n_out = res.size();
        if (n_out > 0) res[n_out - 1].last = 1'b1;
        foreach (res[i]) pending_results.push_back(res[i]);
        store_older[c] = store_newer[c];
        store_newer[c] = pix;
        for (int k = 0; k < 3; k++) begin
            win_cols[3 + k] = win_cols[k];
            win_cols[k] = 8'(grid[2][k]);
        end
        if (c == w - 1) begin
            pm_col = 0;
            pm_row = (r == h - 1) ? 0 : r + 1;
        end else begin
            pm_col = c + 1;
            pm_row = r;
        end
    endtask

    // monitor: input acceptance feeds the predictor, outputs are checked
    always @(posedge clk) begin
        window_result_t want;
        in_taken <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready) begin
            window_step(pixel);
            n_accepted++;
        end
        if (rst_n && out_valid && out_ready) begin
            n_seen++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result row %0d col %0d measure %0d",
                             out_row, out_col, measure);
            end else begin
                want = pending_results.pop_front();
                if (want != {measure, out_row, out_col, run_last, frame_end}) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp m=%0d r=%0d c=%0d last=%0b end=%0b",
                                  " got m=%0d r=%0d c=%0d last=%0b end=%0b"},
                                 want.measure, want.row, want.col, want.last,
                                 want.fend, measure, out_row, out_col, run_last,
                                 frame_end);
                end
            end
        end
    end

    // pixel driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // hold request until accepted
        end else if (send_gap > 0) begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pixel_queue.size() > 0) begin
            pixel <= pixel_queue.pop_front();
            in_valid <= 1'b1;
            if ($urandom_range(0, 19) == 0) fast_send = !fast_send;
            send_gap <= fast_send ? 0 : $urandom_range(0, 15);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (!hold_done && n_seen >= 20) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (out_taken || take_gap == 0) begin
            if ($urandom_range(0, 19) == 0) fast_take = !fast_take;
            if (out_taken && !fast_take) begin
                take_gap <= $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end else begin
            take_gap <= take_gap - 1;
            out_ready <= (take_gap == 1);
        end
    end

    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain_and_settle();
        while (n_accepted != n_sent || pending_results.size() != 0
               || pixel_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [10:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_MODE) begin
            pm_mode = data[1:0];
        end else if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
            if (idx == REG_WIDTH) pm_width = data;
            else pm_height = data;
            pm_row = 0;
            pm_col = 0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixels(int count, int style);
        logic [7:0] v;
        for (int i = 0; i < count; i++) begin
            case (style)
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = (i % 2) ? 8'hFF : 8'h00;
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 8'h00;
                        1: v = 8'hFF;
                        default: v = 8'($urandom);
                    endcase
                end
            endcase
            pixel_queue.push_back(v);
            n_sent++;
        end
    endtask

    task automatic new_shape(logic [1:0] mode, logic [10:0] w, logic [10:0] h);
        drain_and_settle();
        reg_write(REG_MODE, {9'd0, mode});
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    initial begin
        int w, h, cnt;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero energy, flat, checkerboard, degenerate sizes
        new_shape(MODE_BOTH, 11'd3, 11'd2);
        send_pixels(6, 0);
        send_pixels(6, 1);
        new_shape(MODE_EDGE, 11'd1, 11'd1);
        send_pixels(2, 2);
        new_shape(MODE_LINE, 11'd2047, 11'd0);
        send_pixels(5, 2);
        new_shape(2'd3, 11'd0, 11'd4);
        reg_write(2'd3, 11'h7FF);
        send_pixels(5, 3);

        // random frames, mostly small, now and then the largest sizes
        while (n_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: begin w = 1024; h = 1; end
                1: begin w = 2; h = $urandom_range(0, 1) ? 1024 : 2047; end
                2: begin w = $urandom_range(0, 1) ? 0 : 2047; h = 3; end
                default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 5); end
            endcase
            new_shape(2'($urandom_range(0, 3)), 11'(w), 11'(h));
            if (w * h > 60 || w > 1024 || h > 1024) cnt = $urandom_range(20, 50);
            else cnt = w * h * $urandom_range(1, 2) + $urandom_range(0, 2);
            send_pixels(cnt, 3);
        end

        drain_and_settle();
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
